@@ hw/rtl/rgb_blink_sequencer_unit_macros.svh @@
// Assertion macros for the checker of the RGB blink sequencer.
`ifndef RGB_BLINK_SEQUENCER_UNIT_MACROS_SVH
`define RGB_BLINK_SEQUENCER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ hw/rtl/rbs_pkg.sv @@
// Types and constants shared by the RGB blink sequencer modules.
`default_nettype none

package rbs_pkg;

  // Action codes of an input item.
  localparam logic [2:0] ACT_TICK       = 3'd0;
  localparam logic [2:0] ACT_RED        = 3'd1;
  localparam logic [2:0] ACT_GREEN      = 3'd2;
  localparam logic [2:0] ACT_BLUE       = 3'd3;
  localparam logic [2:0] ACT_BIND_START = 3'd4;
  localparam logic [2:0] ACT_BIND_STOP  = 3'd5;

  localparam logic [7:0]  LEVEL_FULL     = 8'd255;
  localparam logic [7:0]  LEVEL_OFF      = 8'd0;
  localparam logic [15:0] PERIOD_DEFAULT = 16'd500;

  // Frame queue geometry.
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = 3;
  localparam int QCNT_W    = 4;
  localparam int BATCH_MAX = 3;

  // One frame for the strip.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } frame_t;

  // Frames produced by one item, packed from index 0 upwards.
  typedef struct packed {
    logic [1:0]       num;
    frame_t [2:0]     frames;
  } frame_batch_t;

endpackage

`default_nettype wire

@@ hw/rtl/rbs_core.sv @@
// Input register, blink state and combinational frame generation.
`default_nettype none

module rbs_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           in_action,
  input  wire logic [15:0]          in_blink_count,
  input  wire logic [15:0]          in_blink_period,
  input  wire logic [31:0]          in_now_ms,
  input  wire logic                 q_room,
  output rbs_pkg::frame_batch_t     push
);

  logic        stage_valid_r, stage_valid_nxt;
  logic [2:0]  act_r;
  logic [15:0] count_r;
  logic [15:0] period_in_r;
  logic [31:0] now_r;
  logic        fire;
  logic        accept;

  logic [15:0] left_r [3];
  logic [15:0] left_nxt [3];
  logic [2:0]  on_r, on_nxt;
  logic [15:0] period_r [3];
  logic [15:0] period_nxt [3];
  logic [31:0] ltt_r [4];
  logic [31:0] ltt_nxt [4];
  logic        bind_active_r, bind_active_nxt;
  logic [15:0] bind_period_r, bind_period_nxt;
  logic        bind_phase_r, bind_phase_nxt;

  logic [2:0]  colour_due;
  logic        bind_due;
  logic [1:0]  cidx;

  // The held item is processed once the frame queue can take a full batch.
  assign fire     = stage_valid_r && q_room;
  assign in_stall = stage_valid_r && !q_room;
  assign accept   = in_valid && !in_stall;
  assign cidx     = act_r[1:0] - 2'd1;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (fire) begin
      stage_valid_nxt = 1'b0;
    end
  end

  // Due checks use the wrapping 32-bit elapsed time.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      colour_due[c] = (left_r[c] != 16'd0) &&
                      ((now_r - ltt_r[c]) >= {16'd0, period_r[c]});
    end
    bind_due = bind_active_r && ((now_r - ltt_r[3]) >= {16'd0, bind_period_r});
  end

  // State update and frame batch for the item in the input register.
  always_comb begin
    rbs_pkg::frame_t f;
    logic [1:0]      n;
    left_nxt        = left_r;
    on_nxt          = on_r;
    period_nxt      = period_r;
    ltt_nxt         = ltt_r;
    bind_active_nxt = bind_active_r;
    bind_period_nxt = bind_period_r;
    bind_phase_nxt  = bind_phase_r;
    push            = '0;
    f               = '0;
    n               = 2'd0;
    if (fire) begin
      unique case (act_r) inside
        rbs_pkg::ACT_RED, rbs_pkg::ACT_GREEN, rbs_pkg::ACT_BLUE: begin
          left_nxt[cidx]   = count_r;
          period_nxt[cidx] = period_in_r;
          on_nxt[cidx]     = 1'b1;
        end
        rbs_pkg::ACT_BIND_START: begin
          bind_active_nxt = 1'b1;
          bind_period_nxt = period_in_r;
          bind_phase_nxt  = 1'b0;
        end
        rbs_pkg::ACT_BIND_STOP: begin
          bind_active_nxt  = 1'b0;
          bind_phase_nxt   = 1'b0;
          f.last           = 1'b1;
          push.frames[0]   = f;
          push.num         = 2'd1;
        end
        rbs_pkg::ACT_TICK: begin
          if (bind_due) begin
            // The binding blink takes the whole tick.
            ltt_nxt[3]     = now_r;
            f.red          = bind_phase_r ? rbs_pkg::LEVEL_FULL : rbs_pkg::LEVEL_OFF;
            f.green        = bind_phase_r ? rbs_pkg::LEVEL_FULL : rbs_pkg::LEVEL_OFF;
            f.blue         = rbs_pkg::LEVEL_OFF;
            f.last         = 1'b1;
            bind_phase_nxt = !bind_phase_r;
            push.frames[0] = f;
            push.num       = 2'd1;
          end else begin
            // Each due colour adds a frame in red, green, blue order.
            for (int c = 0; c < 3; c++) begin
              if (colour_due[c]) begin
                ltt_nxt[c] = now_r;
                f.red   = (c == 0 && on_r[c]) ? rbs_pkg::LEVEL_FULL : rbs_pkg::LEVEL_OFF;
                f.green = (c == 1 && on_r[c]) ? rbs_pkg::LEVEL_FULL : rbs_pkg::LEVEL_OFF;
                f.blue  = (c == 2 && on_r[c]) ? rbs_pkg::LEVEL_FULL : rbs_pkg::LEVEL_OFF;
                f.last  = 1'b0;
                if (!on_r[c]) begin
                  left_nxt[c] = left_r[c] - 16'd1;
                end
                on_nxt[c]       = !on_r[c];
                push.frames[n]  = f;
                n               = n + 2'd1;
              end
            end
            if (n != 2'd0) begin
              push.frames[n - 2'd1].last = 1'b1;
            end
            push.num = n;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Input register: payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r       <= in_action;
      count_r     <= in_blink_count;
      period_in_r <= in_blink_period;
      now_r       <= in_now_ms;
    end
  end

  // Control and blink state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      on_r          <= '0;
      bind_active_r <= 1'b0;
      bind_period_r <= rbs_pkg::PERIOD_DEFAULT;
      bind_phase_r  <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        left_r[c]   <= 16'd0;
        period_r[c] <= rbs_pkg::PERIOD_DEFAULT;
      end
      for (int t = 0; t < 4; t++) begin
        ltt_r[t] <= 32'd0;
      end
    end else begin
      stage_valid_r <= stage_valid_nxt;
      on_r          <= on_nxt;
      bind_active_r <= bind_active_nxt;
      bind_period_r <= bind_period_nxt;
      bind_phase_r  <= bind_phase_nxt;
      left_r        <= left_nxt;
      period_r      <= period_nxt;
      ltt_r         <= ltt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rbs_frame_q.sv @@
// Frame queue that takes a batch of up to three frames and sends one a cycle while the output is not stalled.
`default_nettype none

module rbs_frame_q (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rbs_pkg::frame_batch_t push,
  output logic                       q_room,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_red_level,
  output logic [7:0]                 out_green_level,
  output logic [7:0]                 out_blue_level,
  output logic                       out_last_frame
);

  rbs_pkg::frame_t                 mem_r [rbs_pkg::QDEPTH];
  logic [rbs_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [rbs_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [rbs_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                            pop;
  rbs_pkg::frame_t                 head;

  // Room for a whole batch keeps the core from ever overrunning the queue.
  assign q_room    = count_r <= rbs_pkg::QCNT_W'(rbs_pkg::QDEPTH - rbs_pkg::BATCH_MAX);
  assign out_valid = count_r != '0;
  assign pop       = out_valid && !out_stall;

  assign head            = mem_r[rd_ptr_r];
  assign out_red_level   = head.red;
  assign out_green_level = head.green;
  assign out_blue_level  = head.blue;
  assign out_last_frame  = head.last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + rbs_pkg::QPTR_W'(push.num);
    rd_ptr_nxt = pop ? rd_ptr_r + rbs_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + rbs_pkg::QCNT_W'(push.num) - rbs_pkg::QCNT_W'(pop);
  end

  // Batch write at consecutive slots.
  always_ff @(posedge clk) begin
    for (int k = 0; k < rbs_pkg::BATCH_MAX; k++) begin
      if (k < int'(push.num)) begin
        mem_r[wr_ptr_r + rbs_pkg::QPTR_W'(k)] <= push.frames[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rgb_blink_sequencer_unit.sv @@
// Top level of the RGB blink sequencer.
// An item is taken into an input register, and a new item can be taken
// every cycle while the frame queue has room; a held item is resolved once
// the frame queue has three free slots, producing all of its frames at once;
// the first frame passes the input register and then the queue. Frames
// leave one per cycle from an eight-entry queue while the output is not
// stalled, so a sustained stream is paced by the frames each item causes
// (up to three for a tick), with items that cause no frame taken every
// cycle while the queue has room. There is no start-up pass after reset.
`default_nettype none

module rgb_blink_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [15:0] in_blink_count,
  input  wire logic [15:0] in_blink_period,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red_level,
  output logic [7:0]       out_green_level,
  output logic [7:0]       out_blue_level,
  output logic             out_last_frame
);

  rbs_pkg::frame_batch_t push;
  logic                  q_room;

  // Blink state and frame generation.
  rbs_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_blink_count  (in_blink_count),
    .in_blink_period (in_blink_period),
    .in_now_ms       (in_now_ms),
    .q_room          (q_room),
    .push            (push)
  );

  // Frame queue towards the strip driver.
  rbs_frame_q u_frame_q (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .q_room          (q_room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_last_frame  (out_last_frame)
  );

endmodule

`default_nettype wire

@@ hw/rtl/rbs_checker.sv @@
// Port-level checker for the RGB blink sequencer and its bind.
`default_nettype none

`include "rgb_blink_sequencer_unit_macros.svh"

module rbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [2:0]  in_action,
  input wire logic [15:0] in_blink_count,
  input wire logic [15:0] in_blink_period,
  input wire logic [31:0] in_now_ms,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_red_level,
  input wire logic [7:0]  out_green_level,
  input wire logic [7:0]  out_blue_level,
  input wire logic        out_last_frame
);

  logic [66:0] in_payload;
  logic [24:0] out_frame;

  // Whole payloads of both channels, for the stability checks.
  assign in_payload = {in_action, in_blink_count, in_blink_period, in_now_ms};
  assign out_frame  = {out_red_level, out_green_level, out_blue_level, out_last_frame};

  // A stalled input transfer keeps its valid and its payload.
  `RBS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_payload))

  // A stalled result transfer keeps its valid.
  `RBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A stalled result keeps its frame.
  `RBS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_frame))

  // The input only waits while frames are queued.
  `RBS_ASSERT_NOW(a_stall_has_frames, in_stall, out_valid)

  // Frames of one item follow without a gap.
  `RBS_ASSERT_NEXT(a_batch_contiguous, out_valid && !out_stall && !out_last_frame, out_valid)

endmodule

bind rgb_blink_sequencer_unit rbs_checker u_rbs_checker (.*);

`default_nettype wire
